@@ rtl/core/sis_pkg.sv @@
// ----------------------------------------------------------------------------
// sis_pkg: shared types for the sorted insertion store
// Word formats, opcode and status codes, controller states and the
// command / status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sis_pkg;

   localparam int unsigned VALUE_W = 32;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DRAIN  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_INSERTED = 2'd0,
      STAT_DROPPED  = 2'd1,
      STAT_DRAINED  = 2'd2,
      STAT_EMPTY    = 2'd3
   } status_type;

   typedef enum logic {
      CTL_IDLE  = 1'b0,
      CTL_DRAIN = 1'b1
   } state_type;

   // request word
   typedef struct packed {
      op_type                     opcode;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   // result word
   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  entry_value;
      logic                       last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic insert;   // place the request value in order
      logic shift;    // pop the head entry, move all cells down
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic                       empty;
      logic                       full;
      logic                       last;   // exactly one entry left
      logic signed [VALUE_W-1:0]  head;
   } dp_status_type;

endpackage

@@ rtl/core/sis_datapath.sv @@
// ----------------------------------------------------------------------------
// sis_datapath: row of compare-and-shift cells
// Each cell compares its entry against the incoming value; an insert
// opens a gap at the first entry not smaller and shifts the tail up.
// A drain pops the head and moves every cell down by one.
// ----------------------------------------------------------------------------
module sis_datapath #(
   parameter int unsigned DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sis_pkg::dp_cmd_type                cmd,
   input  logic signed [sis_pkg::VALUE_W-1:0] ins_value,
   output sis_pkg::dp_status_type             status
);
   import sis_pkg::*;

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic signed [VALUE_W-1:0] entry_ff [DEPTH];
   logic signed [VALUE_W-1:0] entry_in [DEPTH];
   logic        [DEPTH-1:0]   lt;
   logic        [CNT_W-1:0]   count_ff;
   logic        [CNT_W-1:0]   count_in;

   // flag occupied cells holding a value smaller than the new one
   for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
      assign lt[i] = (CNT_W'(i) < count_ff) && (entry_ff[i] < ins_value);
   end

   // select each cell's next entry: keep, take new value, or shift
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      always_comb begin
         entry_in[i] = entry_ff[i];
         if (cmd.insert) begin
            if (!lt[i]) begin
               if (i == 0) begin
                  entry_in[i] = ins_value;
               end else begin
                  entry_in[i] = lt[(i == 0) ? 0 : i-1] ? ins_value
                                                       : entry_ff[(i == 0) ? 0 : i-1];
               end
            end
         end else if (cmd.shift) begin
            entry_in[i] = entry_ff[(i == DEPTH-1) ? i : i+1];
         end
      end

      always_ff @(posedge clock) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   // track fill count
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.shift) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.last  = (count_ff == CNT_W'(1));
   assign status.head  = entry_ff[0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !status.full)
      else $error("insert issued into full store");

   a_no_shift_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |-> !status.empty)
      else $error("pop issued on empty store");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (entry_ff[0] <= entry_ff[1]))
      else $error("head entries out of order");

endmodule

@@ rtl/core/sis_ctrl.sv @@
// ----------------------------------------------------------------------------
// sis_ctrl: request sequencer and result register
// Decodes each request, issues insert or pop commands to the datapath and
// registers at most one result word per cycle.
// ----------------------------------------------------------------------------
module sis_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  sis_pkg::req_type       req_data,
   output logic                   busy,
   output logic                   rsp_valid,
   output sis_pkg::rsp_type       rsp_data,
   output sis_pkg::dp_cmd_type    cmd,
   input  sis_pkg::dp_status_type status
);
   import sis_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;
   logic      accept;

   assign busy   = (state_ff == CTL_DRAIN);
   assign accept = start && !busy;

   // next state, datapath commands and next result word
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '{status: STAT_INSERTED, entry_value: '0, last: 1'b1};
      unique case (state_ff)
         CTL_IDLE: begin
            if (accept) begin
               if (req_data.opcode == OP_INSERT) begin
                  rsp_valid_in = 1'b1;
                  if (status.full) begin
                     rsp_data_in.status = STAT_DROPPED;
                  end else begin
                     cmd.insert = 1'b1;
                  end
               end else if (status.empty) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = STAT_EMPTY;
               end else begin
                  state_in = CTL_DRAIN;
               end
            end
         end
         CTL_DRAIN: begin
            cmd.shift               = 1'b1;
            rsp_valid_in            = 1'b1;
            rsp_data_in.status      = STAT_DRAINED;
            rsp_data_in.entry_value = status.head;
            rsp_data_in.last        = status.last;
            if (status.last) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTL_DRAIN) |-> !status.empty)
      else $error("drain running on empty store");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTL_DRAIN && status.last) |=> (state_ff == CTL_IDLE) && rsp_data.last)
      else $error("drain did not close with a last word");

   a_insert_result: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> rsp_valid && (rsp_data.status == STAT_INSERTED))
      else $error("insert without inserted result");

endmodule

@@ rtl/core/sorted_insertion_store.sv @@
// ----------------------------------------------------------------------------
// sorted_insertion_store: ascending store of signed 32-bit values
// Inserts keep the store sorted; a drain streams all entries in ascending
// order, flags the final one, and empties the store.
// ----------------------------------------------------------------------------
//
//  channel   ports                         direction  handshake
//  request   start, busy, req_data         in         start && !busy
//  result    rsp_valid, rsp_data           out        rsp_valid, one cycle
//
//  Insert: the result word appears the cycle after acceptance and busy
//    stays low, so a new request may follow at once.
//  Drain of N entries: busy is high while the entries are popped, one
//    word per cycle set by the single head pop of the cell row.
//  Drain of an empty store: a single empty word.
//  Reset clears the fill count and the sequencer; no clearing pass.
//  The receiver takes every word as it comes; there is no back-pressure.
//
module sorted_insertion_store #(
   parameter int unsigned DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  sis_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output sis_pkg::rsp_type rsp_data
);
   import sis_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   sis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

   sis_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .ins_value (req_data.value),
      .status    (status)
   );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted insertion store
// Sends insert and drain commands, predicts every status word with a shadow
// copy of the sorted store and checks each word the block sends back.
// ----------------------------------------------------------------------------
module tb;
   import sis_pkg::*;

   localparam int unsigned STORE_DEPTH = 32;
   localparam int          ITEM_TARGET = 250;
   localparam int          STALL_LIMIT = 2000;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow store plus the queue of words still due
   // -------------------------------------------------------------------------
   class store_scoreboard;
      logic signed [VALUE_W-1:0] shadow_entries[$];
      rsp_type                   words_due[$];
      int                        error_count;
      int                        depth;

      function new(int d);
         depth       = d;
         error_count = 0;
      endfunction

      // Work out the words an accepted command causes and queue them
      function void note_request(req_type w);
         rsp_type word;
         int      pos;
         int      n;
         word = '0;
         if (w.opcode == OP_INSERT) begin
            word.last = 1'b1;
            if (shadow_entries.size() >= depth) begin
               word.status = STAT_DROPPED;
            end else begin
               // place in front of the first entry that is not smaller
               pos = 0;
               while (pos < shadow_entries.size() && shadow_entries[pos] < w.value)
                  pos++;
               shadow_entries.insert(pos, w.value);
               word.status = STAT_INSERTED;
            end
            words_due.push_back(word);
         end else if (shadow_entries.size() == 0) begin
            word.status = STAT_EMPTY;
            word.last   = 1'b1;
            words_due.push_back(word);
         end else begin
            // stream all entries ascending, flag the final one
            n = shadow_entries.size();
            for (int k = 0; k < n; k++) begin
               word.status      = STAT_DRAINED;
               word.entry_value = shadow_entries[k];
               word.last        = (k == n - 1);
               words_due.push_back(word);
            end
            shadow_entries.delete();
         end
      endfunction

      // Compare one returned word against the oldest expected one
      function void check_result(rsp_type got);
         rsp_type exp;
         if (words_due.size() == 0) begin
            $display("%0t: unexpected word: status %0d value %0d last %0b",
                     $time, got.status, got.entry_value, got.last);
            error_count++;
            return;
         end
         exp = words_due.pop_front();
         if (got.status !== exp.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, exp.status, got.status);
            error_count++;
         end
         if (got.entry_value !== exp.entry_value) begin
            $display("%0t: entry_value mismatch: expected %0d, got %0d",
                     $time, exp.entry_value, got.entry_value);
            error_count++;
         end
         if (got.last !== exp.last) begin
            $display("%0t: last mismatch: expected %0b, got %0b",
                     $time, exp.last, got.last);
            error_count++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   store_scoreboard sb;
   int              items_sent;
   int              idle_pct;
   int              stall_cycles;

   sorted_insertion_store #(
      .DEPTH(STORE_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor and watchdog: sample handshakes at the rising edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_request(req_data);
         if (rsp_valid)
            sb.check_result(rsp_data);
         if ((start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Pick a value: full range, a tight cluster for equal values, or an extreme
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         1, 2:    return $signed($urandom_range(0, 8)) - 4;
         3: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7FFF_FFFF;
               2:       return '0;
               default: return -1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Send one command word; idle beforehand as the current phase asks
   task automatic send_word(input op_type op, input logic signed [VALUE_W-1:0] v);
      req_type w;
      idle_pct = (items_sent < ITEM_TARGET / 3)     ? 11 :
                 (items_sent < 2 * ITEM_TARGET / 3) ? 79 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      w.opcode = op;
      w.value  = v;
      start    <= 1'b1;
      req_data <= w;
      // hold until the block takes the word
      do @(posedge clock); while (busy);
      items_sent++;
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int fill;

      sb           = new(STORE_DEPTH);
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      items_sent   = 0;
      stall_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty drain, first entry, extremes, equal values
      send_word(OP_DRAIN,  32'sd0);
      send_word(OP_INSERT, 32'sd0);
      send_word(OP_INSERT, 32'sh7FFF_FFFF);
      send_word(OP_INSERT, 32'sh8000_0000);
      send_word(OP_INSERT, -32'sd1);
      send_word(OP_INSERT, 32'sd1);
      send_word(OP_INSERT, 32'sd0);
      send_word(OP_INSERT, 32'sh8000_0000);
      send_word(OP_INSERT, 32'shAAAA_AAAA);
      send_word(OP_INSERT, 32'sh5555_5555);
      send_word(OP_DRAIN,  32'shFFFF_FFFF);
      send_word(OP_INSERT, 32'sd5);
      send_word(OP_DRAIN,  32'sd0);
      send_word(OP_DRAIN,  32'sh7FFF_FFFF);

      // random fill-then-drain runs; the first one sends more words than the store holds
      fill = STORE_DEPTH + $urandom_range(1, 4);
      while (items_sent < ITEM_TARGET) begin
         for (int i = 0; i < fill; i++) begin
            // occasional stray drain breaks up a run
            if ($urandom_range(0, 11) == 0)
               send_word(OP_DRAIN, $urandom);
            else
               send_word(OP_INSERT, pick_value());
         end
         send_word(OP_DRAIN, $urandom);
         fill = ($urandom_range(0, 3) == 0) ? STORE_DEPTH + $urandom_range(0, 4)
                                            : $urandom_range(0, 12);
      end
      start <= 1'b0;

      // drop out once every expected word is back, then let the block settle
      while (sb.words_due.size() != 0)
         @(negedge clock);
      repeat (STORE_DEPTH + 4) @(negedge clock);

      if (sb.error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/sis_pkg.sv
rtl/core/sis_datapath.sv
rtl/core/sis_ctrl.sv
rtl/core/sorted_insertion_store.sv
tb/tb.sv
